[design/dlr_pkg.sv]
// Shared constants and word layouts for the dashed line rasterizer.
package dlr_pkg;

   localparam int unsigned COORD_BITS_DEF = 16;   // default coordinate width
   localparam int unsigned FIELD_W        = 16;   // width of a coordinate field
   localparam int unsigned SPACING_W      = 16;
   localparam int unsigned COLOR_W        = 32;
   localparam int unsigned PHASE_W        = SPACING_W;

   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned RSP_USER_W = 1;

   // request kind, carried on req_tuser
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   // request word, last field (start_x) in the lowest bits
   typedef struct packed {
      logic [COLOR_W-1:0]   line_color;
      logic [SPACING_W-1:0] dash_spacing;
      logic [FIELD_W-1:0]   end_y;
      logic [FIELD_W-1:0]   end_x;
      logic [FIELD_W-1:0]   start_y;
      logic [FIELD_W-1:0]   start_x;
   } req_data_type;

   // response word, last field (pixel_x) in the lowest bits, zero pad on top
   typedef struct packed {
      logic [6:0]           pad;
      logic [COLOR_W-1:0]   pixel_color;
      logic                 draw;
      logic [FIELD_W-1:0]   pixel_y;
      logic [FIELD_W-1:0]   pixel_x;
   } rsp_data_type;

endpackage

[design/dashed_line_rasterizer.sv]
// Dashed line rasterizer: Bresenham stepper with a dash pattern, one pixel per step word.
//
//   channel | dir | tdata (low bit up)                                   | tuser   | tlast
//   req_    | in  | start_x, start_y, end_x, end_y, dash_spacing, color  | opcode  | -
//   rsp_    | out | pixel_x, pixel_y, draw, pixel_color, 7 pad bits       | active  | last
//
// A word is taken into an input register and handled from there: a
// start word loads the stepper, a step word updates it and writes one result
// word into the output register. One word per clock sustained while the
// output register is free or taken; a stalled result holds step words back.
// The rate is set by the single add/compare/increment step on the stepper registers.
// Synchronous active-high reset clears the valid flags and the busy flag.
// A stalled result holds a step word in the input register; a start word there
// is loaded even while the result waits.
module dashed_line_rasterizer #(
   parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x[15:0] start_y[31:16] end_x[47:32] end_y[63:48]
   // dash_spacing[79:64] line_color[111:80]
   input  logic [dlr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode[0]
   input  logic [dlr_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_x[15:0] pixel_y[31:16] draw[32] pixel_color[64:33] zero pad[71:65]
   output logic [dlr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // active[0]
   output logic [dlr_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);
   import dlr_pkg::*;

   localparam int unsigned CW = COORD_BITS;   // coordinate / delta width
   localparam int unsigned EW = CW + 1;       // difference and error sum width

   // input register
   logic         in_valid_ff, in_valid_in;
   op_type       in_op_ff, in_op_in;
   req_data_type in_data_ff, in_data_in;

   // stepper state
   logic                 busy_ff, busy_in;
   logic [CW-1:0]        cur_x_ff, cur_x_in;
   logic [CW-1:0]        cur_y_ff, cur_y_in;
   logic [CW-1:0]        err_ff, err_in;
   logic [CW-1:0]        major_ff, major_in;
   logic [CW-1:0]        minor_ff, minor_in;
   logic [CW-1:0]        left_ff, left_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [SPACING_W-1:0] spacing_ff, spacing_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 xmajor_ff, xmajor_in;
   logic                 xdown_ff, xdown_in;
   logic                 ydown_ff, ydown_in;

   // output register
   logic         out_valid_ff, out_valid_in;
   logic         out_active_ff, out_active_in;
   logic         out_last_ff, out_last_in;
   rsp_data_type out_data_ff, out_data_in;

   // handshake
   logic req_fire, out_free, proc, rsp_load;

   // start setup
   logic [CW-1:0]        ax, ay, bx, by;
   logic signed [EW-1:0] diff_x, diff_y;
   logic [EW-1:0]        mag_x, mag_y;
   logic [CW-1:0]        dx, dy;
   logic                 xneg, yneg, xmaj_new;

   // step
   logic [EW-1:0]  err_sum;
   logic           minor_step, x_move, y_move;
   logic [CW-1:0]  step_x, step_y;
   logic [PHASE_W:0] phase_sum;
   logic           drawn;

   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign proc       = in_valid_ff & ((in_op_ff == OP_START) | out_free);
   assign rsp_load   = proc & (in_op_ff == OP_STEP);
   assign req_tready = ~in_valid_ff | proc;

   // input register next state
   always_comb begin
      in_op_in   = in_op_ff;
      in_data_in = in_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_op_in    = op_type'(req_tuser[0]);
         in_data_in  = req_data_type'(req_tdata);
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // start word: endpoints cut (or zero-extended) to CW bits, then signed deltas
   always_comb begin
      ax = CW'(in_data_ff.start_x);
      ay = CW'(in_data_ff.start_y);
      bx = CW'(in_data_ff.end_x);
      by = CW'(in_data_ff.end_y);
      diff_x = EW'(signed'(bx)) - EW'(signed'(ax));
      diff_y = EW'(signed'(by)) - EW'(signed'(ay));
      xneg   = diff_x[EW-1];
      yneg   = diff_y[EW-1];
      mag_x  = xneg ? (~diff_x + EW'(1)) : diff_x;
      mag_y  = yneg ? (~diff_y + EW'(1)) : diff_y;
      dx     = mag_x[CW-1:0];
      dy     = mag_y[CW-1:0];
      xmaj_new = (dx >= dy);
   end

   // step word: error accumulate, axis moves, dash phase
   always_comb begin
      err_sum    = {1'b0, err_ff} + {1'b0, minor_ff};
      minor_step = (err_sum >= {1'b0, major_ff});
      x_move     = xmajor_ff | minor_step;
      y_move     = ~xmajor_ff | minor_step;
      step_x     = xdown_ff ? {CW{1'b1}} : CW'(1);
      step_y     = ydown_ff ? {CW{1'b1}} : CW'(1);
      phase_sum  = {1'b0, phase_ff} + (PHASE_W + 1)'(1);
      drawn      = (spacing_ff == '0) | (phase_ff >= (spacing_ff >> 1));
   end

   // stepper and result next state
   always_comb begin
      busy_in    = busy_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      left_in    = left_ff;
      phase_in   = phase_ff;
      spacing_in = spacing_ff;
      color_in   = color_ff;
      xmajor_in  = xmajor_ff;
      xdown_in   = xdown_ff;
      ydown_in   = ydown_ff;

      out_active_in = out_active_ff;
      out_last_in   = out_last_ff;
      out_data_in   = out_data_ff;

      if (proc && in_op_ff == OP_START) begin
         // new line replaces any line in progress
         xmajor_in  = xmaj_new;
         xdown_in   = xneg;
         ydown_in   = yneg;
         major_in   = xmaj_new ? dx : dy;
         minor_in   = xmaj_new ? dy : dx;
         err_in     = (xmaj_new ? dx : dy) >> 1;
         left_in    = xmaj_new ? dx : dy;
         cur_x_in   = ax;
         cur_y_in   = ay;
         spacing_in = in_data_ff.dash_spacing;
         color_in   = in_data_ff.line_color;
         phase_in   = (in_data_ff.dash_spacing == SPACING_W'(1)) ? '0 : PHASE_W'(1);
         busy_in    = ((xmaj_new ? dx : dy) != '0);
      end else if (rsp_load) begin
         out_data_in.pad = '0;
         if (busy_ff) begin
            out_active_in           = 1'b1;
            out_last_in             = (left_ff == CW'(1));
            out_data_in.pixel_x     = FIELD_W'(signed'(cur_x_ff));
            out_data_in.pixel_y     = FIELD_W'(signed'(cur_y_ff));
            out_data_in.draw        = drawn;
            out_data_in.pixel_color = color_ff;

            err_in = minor_step ? CW'(err_sum - {1'b0, major_ff}) : err_sum[CW-1:0];
            if (x_move) begin
               cur_x_in = cur_x_ff + step_x;
            end
            if (y_move) begin
               cur_y_in = cur_y_ff + step_y;
            end
            if (spacing_ff != '0) begin
               phase_in = (phase_sum >= {1'b0, spacing_ff}) ? '0 : phase_sum[PHASE_W-1:0];
            end
            left_in = left_ff - CW'(1);
            busy_in = (left_ff != CW'(1));
         end else begin
            // idle step: empty result
            out_active_in           = 1'b0;
            out_last_in             = 1'b0;
            out_data_in.pixel_x     = '0;
            out_data_in.pixel_y     = '0;
            out_data_in.draw        = 1'b0;
            out_data_in.pixel_color = '0;
         end
      end

      if (rsp_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         busy_ff      <= busy_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_data_ff    <= in_data_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      err_ff        <= err_in;
      major_ff      <= major_in;
      minor_ff      <= minor_in;
      left_ff       <= left_in;
      phase_ff      <= phase_in;
      spacing_ff    <= spacing_in;
      color_ff      <= color_in;
      xmajor_ff     <= xmajor_in;
      xdown_ff      <= xdown_in;
      ydown_ff      <= ydown_in;
      out_active_ff <= out_active_in;
      out_last_ff   <= out_last_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'(out_data_ff);
   assign rsp_tuser[0] = out_active_ff;
   assign rsp_tlast    = out_last_ff;

`ifndef SYNTHESIS
   // a line in progress always has pixels left
   a_busy_left: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (left_ff != '0))
      else $error("busy with no pixels left");

   // error numerator stays below the major delta
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (err_ff < major_ff))
      else $error("error accumulator out of range");

   // dash phase wraps inside the period
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && spacing_ff != '0) |-> (phase_ff < spacing_ff))
      else $error("dash phase out of range");

   // final pixel ends the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && busy_ff && left_ff == CW'(1)) |=> (!busy_ff && out_last_ff))
      else $error("line not closed after final pixel");

   // tlast only on a real pixel
   a_last_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("tlast on an empty result");
`endif

endmodule

[tb/tb_dashed_line_rasterizer.sv]
// Self-checking testbench for the dashed line rasterizer: random and directed line words.
`timescale 1ns / 100ps

module tb_dashed_line_rasterizer;
   import dlr_pkg::*;

   typedef struct {
      op_type       op;
      req_data_type data;
   } line_word_type;

   typedef struct {
      logic        active;
      logic [15:0] x;
      logic [15:0] y;
      logic        draw;
      logic [31:0] color;
      logic        last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   line_word_type pending_words[$];
   pixel_type     expected_pixels[$];
   int            total_words = 1;
   int            words_taken = 0;
   int            mismatches = 0;
   logic          req_took = 1'b0;
   int            hold_left = 0;
   logic          hold_done = 1'b0;

   // stepper copy
   logic        line_busy = 1'b0;
   logic [15:0] pos_x = '0, pos_y = '0;
   logic [16:0] err_acc = '0;
   logic [15:0] major_d = '0, minor_d = '0;
   logic [16:0] pixels_to_go = '0;
   logic [15:0] dash_pos = '0, dash_period = '0;
   logic [31:0] line_rgba = '0;
   logic        x_major = 1'b0, x_down = 1'b0, y_down = 1'b0;

   dashed_line_rasterizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [15:0] step_coord(input logic [15:0] c, input logic down);
      return down ? c - 16'd1 : c + 16'd1;
   endfunction

   // Start words load the stepper; step words yield one expected pixel.
   function automatic void trace_line(input op_type op, input req_data_type w);
      pixel_type   px;
      int          ax, ay, bx, by, dx, dy;
      logic [16:0] err_sum;
      px = '{default: '0};
      if (op == OP_START) begin
         ax = int'($signed(w.start_x));
         ay = int'($signed(w.start_y));
         bx = int'($signed(w.end_x));
         by = int'($signed(w.end_y));
         dx = (bx >= ax) ? bx - ax : ax - bx;
         dy = (by >= ay) ? by - ay : ay - by;
         x_major = (dx >= dy);
         x_down = (bx < ax);
         y_down = (by < ay);
         major_d = x_major ? 16'(dx) : 16'(dy);
         minor_d = x_major ? 16'(dy) : 16'(dx);
         err_acc = {1'b0, major_d >> 1};
         pixels_to_go = {1'b0, major_d};
         pos_x = w.start_x;
         pos_y = w.start_y;
         dash_period = w.dash_spacing;
         line_rgba = w.line_color;
         dash_pos = (dash_period == 16'd1) ? 16'd0 : 16'd1;
         line_busy = (major_d != 16'd0);
         return;
      end
      if (line_busy) begin
         px.active = 1'b1;
         px.x = pos_x;
         px.y = pos_y;
         px.draw = (dash_period == 16'd0) || (dash_pos >= (dash_period >> 1));
         px.color = line_rgba;
         px.last = (pixels_to_go == 17'd1);
         err_sum = err_acc + minor_d;
         if (err_sum >= major_d) begin
            err_sum = err_sum - major_d;
            if (x_major) pos_y = step_coord(pos_y, y_down);
            else pos_x = step_coord(pos_x, x_down);
         end
         err_acc = err_sum;
         if (x_major) pos_x = step_coord(pos_x, x_down);
         else pos_y = step_coord(pos_y, y_down);
         if (dash_period != 16'd0) begin
            dash_pos = dash_pos + 16'd1;
            if (dash_pos >= dash_period) dash_pos = '0;
         end
         pixels_to_go = pixels_to_go - 17'd1;
         if (pixels_to_go == 17'd0) line_busy = 1'b0;
      end
      expected_pixels.push_back(px);
   endfunction

   task automatic add_start(input int sx, input int sy, input int ex, input int ey,
                            input logic [15:0] spacing, input logic [31:0] rgba);
      line_word_type lw;
      lw.op = OP_START;
      lw.data.start_x = 16'(sx);
      lw.data.start_y = 16'(sy);
      lw.data.end_x = 16'(ex);
      lw.data.end_y = 16'(ey);
      lw.data.dash_spacing = spacing;
      lw.data.line_color = rgba;
      pending_words.push_back(lw);
   endtask

   // Step words carry random payload; the block ignores it.
   task automatic add_steps(input int n);
      line_word_type lw;
      repeat (n) begin
         lw.op = OP_STEP;
         lw.data = {$urandom, $urandom, $urandom, 16'($urandom)};
         pending_words.push_back(lw);
      end
   endtask

   function automatic int end_near(input int a, input int d);
      return (a + d > 32767 || a + d < -32768) ? a - d : a + d;
   endfunction

   task automatic build_stimulus();
      int            sx, sy, ex, ey, len, r;
      logic [15:0]   spacing;
      line_word_type lw;
      // step with no line, zero-length line
      add_steps(1);
      add_start(5, 5, 5, 5, 16'd3, 32'h1234_5678);
      add_steps(1);
      // solid shallow line, plus one step past its end
      add_start(0, 0, 3, 1, 16'd0, 32'hA5A5_5A5A);
      add_steps(4);
      // full-extent diagonal, cut short by the next start
      add_start(-32768, -32768, 32767, 32767, 16'hFFFF, 32'hFFFF_FFFF);
      add_steps(2);
      // steep line stepping down on both axes, spacing one
      add_start(32767, 32767, 32764, 32760, 16'd1, 32'h0000_0000);
      add_steps(8);
      // exact diagonal, x down y up
      add_start(0, 0, -3, 3, 16'd4, 32'h8000_0001);
      add_steps(3);

      while (pending_words.size() < 1250) begin
         r = $urandom_range(0, 99);
         if (r < 95) begin
            sx = int'($signed(16'($urandom)));
            sy = int'($signed(16'($urandom)));
            if ($urandom_range(0, 19) == 0) begin
               ex = sx;
               ey = sy;
            end else begin
               ex = end_near(sx, $urandom_range(0, 24));
               ey = end_near(sy, $urandom_range(0, 24));
            end
            case ($urandom_range(0, 9))
               0: spacing = 16'($urandom);
               1, 2: spacing = 16'($urandom_range(10, 40));
               default: spacing = 16'($urandom_range(0, 9));
            endcase
            if (r >= 90) begin
               // wide line, dropped after a few pixels
               ex = int'($signed(16'($urandom)));
               ey = int'($signed(16'($urandom)));
            end
            add_start(sx, sy, ex, ey, spacing, $urandom);
            len = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) > len) len = (ey > sy ? ey - sy : sy - ey);
            if (r < 80) add_steps(len + $urandom_range(0, 2));
            else if (r < 90) add_steps($urandom_range(0, len));
            else add_steps($urandom_range(0, 6));
         end else begin
            lw.op = op_type'($urandom_range(0, 1));
            lw.data = {$urandom, $urandom, $urandom, 16'($urandom)};
            pending_words.push_back(lw);
         end
      end
      total_words = pending_words.size();
   endtask

   // idle percentage per phase: receiver-heavy, sender-heavy, then none
   function automatic int idle_pct(input logic receiver);
      case ((words_taken * 3) / total_words)
         0: return receiver ? 60 : 21;
         1: return receiver ? 21 : 60;
         default: return 0;
      endcase
   endfunction

   // sender: hold a word until taken, then maybe idle
   always @(negedge clock) begin
      line_word_type lw;
      if (!reset && (!req_tvalid || req_took)) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
            lw = pending_words.pop_front();
            req_tdata <= lw.data;
            req_tuser <= lw.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random backpressure plus one long hold-off late in the run
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && words_taken >= (total_words * 3) / 4) begin
         hold_done <= 1'b1;
         hold_left <= 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
   end

   // monitor: predict on accepted request words, check accepted result words
   always @(posedge clock) begin
      pixel_type    px;
      rsp_data_type rd;
      req_took = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_took = 1'b1;
            words_taken++;
            trace_line(op_type'(req_tuser[0]), req_data_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            rd = rsp_data_type'(rsp_tdata);
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected pixel word active=%b x=%h y=%h", $realtime,
                           rsp_tuser[0], rd.pixel_x, rd.pixel_y);
            end else begin
               px = expected_pixels.pop_front();
               if (rsp_tuser[0] !== px.active || rd.pixel_x !== px.x || rd.pixel_y !== px.y ||
                   rd.draw !== px.draw || rd.pixel_color !== px.color ||
                   rsp_tlast !== px.last || rd.pad !== 7'd0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pixel mismatch exp a=%b x=%h y=%h d=%b c=%h l=%b",
                              $realtime, px.active, px.x, px.y, px.draw, px.color, px.last,
                              " got a=%b x=%h y=%h d=%b c=%h l=%b pad=%h",
                              rsp_tuser[0], rd.pixel_x, rd.pixel_y, rd.draw,
                              rd.pixel_color, rsp_tlast, rd.pad);
               end
            end
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_words.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
design/dlr_pkg.sv
design/dashed_line_rasterizer.sv
tb/tb_dashed_line_rasterizer.sv
